@@ design/gndep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gndep_pkg
// Shared types and codes for the greedy neighbor deposit step block.
// ----------------------------------------------------------------------------
package gndep_pkg;

   // item kinds carried in req_tuser
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_STEP = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   // result status carried in rsp_tuser
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [1:0] STAT_ZERO    = 2'd2;
   localparam logic [1:0] STAT_NONE    = 2'd3;

   // register indexes on the csr channel
   localparam logic [7:0] REG_GRID_WIDTH  = 8'd0;
   localparam logic [7:0] REG_GRID_HEIGHT = 8'd1;

   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 48;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_NB_ADDR,
      ST_NB_MUL,
      ST_NB_GAIN,
      ST_NB_PICK,
      ST_CTR_RD,
      ST_CTR_DATA,
      ST_BEST_RD,
      ST_BEST_WR,
      ST_OUT
   } state_type;

   // x offset of a direction code, 10-bit two's complement (0 east, ccw)
   function automatic logic [9:0] dir_dx(input logic [2:0] code);
      logic [9:0] d;
      case (code)
         3'd0, 3'd1, 3'd7: d = 10'd1;
         3'd3, 3'd4, 3'd5: d = 10'h3FF;
         default:          d = 10'd0;
      endcase
      return d;
   endfunction

   // y offset of a direction code, y grows upward
   function automatic logic [9:0] dir_dy(input logic [2:0] code);
      logic [9:0] d;
      case (code)
         3'd1, 3'd2, 3'd3: d = 10'd1;
         3'd5, 3'd6, 3'd7: d = 10'h3FF;
         default:          d = 10'd0;
      endcase
      return d;
   endfunction

endpackage

@@ design/greedy_neighbor_deposit_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_neighbor_deposit_step
// Sample and field grids in block memory with a greedy neighbor deposit.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one transaction per item: load a cell, take a deposit
//   step at a cell, or read a cell (kind in req_tuser). rsp returns exactly
//   one transaction per item, status in rsp_tuser.
//   csr writes grid_width (index 0) and grid_height (index 1); write only
//   while the block is idle. csr_ready is always high.
// Flow (one item at a time, req_tready high only when idle): out-of-grid or
//   load items go straight to output; reads and zero-total steps read the
//   center cell; a step sends each in-grid neighbor through the two-stage
//   gain unit in turn, skips out-of-grid directions, then updates the best
//   cell if one was found. The grid memories have a single read port.
// Reset clears totals, sizes (256 x 256) and handshakes; grid contents are
//   undefined until loaded.
// A stalled rsp holds its transaction; the block still takes the next req
//   item and waits in its final state until the output register frees up.
// ----------------------------------------------------------------------------
module greedy_neighbor_deposit_step #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // cell_x, cell_y, sample_value, field_value, direction_order
   input  logic [gndep_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // action
   input  logic [1:0]                           req_tuser,
   // rsp
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // chosen_x, chosen_y, sample_out, field_out
   output logic [gndep_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // status
   output logic [1:0]                           rsp_tuser,
   // csr
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [7:0]                           csr_index,
   input  logic [8:0]                           csr_data
);
   import gndep_pkg::*;

   localparam int CAP_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int CAP_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
   localparam int XW    = $clog2(CAP_W);
   localparam int YW    = $clog2(CAP_H);
   localparam int AW    = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam int CB    = COUNT_BITS;
   localparam logic [8:0]  CAP_W9  = 9'(CAP_W);
   localparam logic [8:0]  CAP_H9  = 9'(CAP_H);
   localparam logic [32:0] CNT_MAX = (33'd1 << CB) - 33'd1;

   state_type state_ff, state_in;

   logic [1:0]  act_ff;
   logic [7:0]  cx_ff, cy_ff;
   logic [15:0] sv_ff, fv_ff;
   logic [23:0] order_ff;
   logic [8:0]  grid_w_ff, grid_h_ff;
   logic [31:0] sample_total_ff, field_total_ff;
   logic [2:0]  k_ff;
   logic        found_ff;
   logic [31:0] best_ff;
   logic [7:0]  best_x_ff, best_y_ff, cand_x_ff, cand_y_ff;
   logic [1:0]  pend_st_ff;
   logic [7:0]  res_x_ff, res_y_ff;
   logic [15:0] res_s_ff, res_f_ff;
   logic [1:0]  res_st_ff;
   logic        rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [1:0]  rsp_st_ff;

   logic [CB-1:0] sample_mem [DEPTH];
   logic [CB-1:0] field_mem  [DEPTH];
   logic [CB-1:0] s_rd_ff, f_rd_ff;

   logic [8:0]    eff_w, eff_h;
   logic          outside;
   logic [CB-1:0] s_sat, f_sat, f_inc;
   logic [2:0]    code;
   logic [9:0]    nx, ny;
   logic          nb_inside;
   logic [AW-1:0] rd_addr, ctr_addr, nb_addr, best_addr;
   logic [31:0]   gain;
   logic          take;
   logic [32:0]   s_total_sum, f_total_sum, f_total_inc;

   // effective grid size and addressing
   always_comb begin
      eff_w     = (grid_w_ff > CAP_W9) ? CAP_W9 : grid_w_ff;
      eff_h     = (grid_h_ff > CAP_H9) ? CAP_H9 : grid_h_ff;
      outside   = ({1'b0, cx_ff} >= eff_w) || ({1'b0, cy_ff} >= eff_h);
      code      = order_ff[3*k_ff +: 3];
      nx        = {2'b00, cx_ff} + dir_dx(code);
      ny        = {2'b00, cy_ff} + dir_dy(code);
      nb_inside = !nx[9] && !ny[9] && (nx[8:0] < eff_w) && (ny[8:0] < eff_h);
      ctr_addr  = {cy_ff[YW-1:0], cx_ff[XW-1:0]};
      nb_addr   = {ny[YW-1:0], nx[XW-1:0]};
      best_addr = {best_y_ff[YW-1:0], best_x_ff[XW-1:0]};
   end

   // saturating counts and totals
   always_comb begin
      s_sat       = CB'((33'(sv_ff) > CNT_MAX) ? CNT_MAX : 33'(sv_ff));
      f_sat       = CB'((33'(fv_ff) > CNT_MAX) ? CNT_MAX : 33'(fv_ff));
      f_inc       = (33'(f_rd_ff) == CNT_MAX) ? f_rd_ff : f_rd_ff + CB'(1);
      s_total_sum = {1'b0, sample_total_ff} + 33'(s_sat);
      f_total_sum = {1'b0, field_total_ff} + 33'(f_sat);
      f_total_inc = {1'b0, field_total_ff} + 33'd1;
      take        = !found_ff || (gain > best_ff);
   end

   // next state and memory read address
   always_comb begin
      state_in = state_ff;
      rd_addr  = ctr_addr;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (outside || act_ff == ACT_LOAD) state_in = ST_OUT;
            else if (act_ff == ACT_STEP && field_total_ff != '0) state_in = ST_NB_ADDR;
            else state_in = ST_CTR_RD;
         end
         ST_NB_ADDR: begin
            rd_addr = nb_addr;
            if (nb_inside) state_in = ST_NB_MUL;
            else if (k_ff == 3'd7) state_in = found_ff ? ST_BEST_RD : ST_CTR_RD;
         end
         ST_NB_MUL:  state_in = ST_NB_GAIN;
         ST_NB_GAIN: state_in = ST_NB_PICK;
         ST_NB_PICK: state_in = (k_ff == 3'd7) ? ST_BEST_RD : ST_NB_ADDR;
         ST_CTR_RD:  state_in = ST_CTR_DATA;
         ST_CTR_DATA: state_in = ST_OUT;
         ST_BEST_RD: begin
            rd_addr  = best_addr;
            state_in = ST_BEST_WR;
         end
         ST_BEST_WR: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // grid memories, one read and one write port each
   always_ff @(posedge clock) begin
      s_rd_ff <= sample_mem[rd_addr];
      f_rd_ff <= field_mem[rd_addr];
      if (state_ff == ST_DISPATCH && !outside && act_ff == ACT_LOAD) begin
         sample_mem[ctr_addr] <= s_sat;
         field_mem[ctr_addr]  <= f_sat;
      end
      if (state_ff == ST_BEST_WR) field_mem[best_addr] <= f_inc;
   end

   gndep_gain #(.COUNT_BITS(CB)) u_gain (
      .clock        (clock),
      .sample_count (s_rd_ff),
      .field_count  (f_rd_ff),
      .sample_total (sample_total_ff),
      .field_total  (field_total_ff),
      .gain         (gain)
   );

   // control state: sizes, totals, search bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff       <= 9'd256;
         grid_h_ff       <= 9'd256;
         sample_total_ff <= '0;
         field_total_ff  <= '0;
         k_ff            <= '0;
         found_ff        <= 1'b0;
      end else begin
         if (csr_valid && csr_index == REG_GRID_WIDTH)  grid_w_ff <= csr_data;
         if (csr_valid && csr_index == REG_GRID_HEIGHT) grid_h_ff <= csr_data;
         case (state_ff)
            ST_DISPATCH: begin
               k_ff     <= '0;
               found_ff <= 1'b0;
               if (!outside && act_ff == ACT_LOAD) begin
                  sample_total_ff <= s_total_sum[32] ? '1 : s_total_sum[31:0];
                  field_total_ff  <= f_total_sum[32] ? '1 : f_total_sum[31:0];
               end
            end
            ST_NB_ADDR: begin
               if (!nb_inside && k_ff != 3'd7) k_ff <= k_ff + 3'd1;
            end
            ST_NB_PICK: begin
               if (take) found_ff <= 1'b1;
               k_ff <= k_ff + 3'd1;
            end
            ST_BEST_WR: begin
               field_total_ff <= f_total_inc[32] ? '1 : f_total_inc[31:0];
            end
            default: ;
         endcase
      end
   end

   // item payload, candidate and result registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            act_ff   <= req_tuser;
            cx_ff    <= req_tdata[7:0];
            cy_ff    <= req_tdata[15:8];
            sv_ff    <= req_tdata[31:16];
            fv_ff    <= req_tdata[47:32];
            order_ff <= req_tdata[71:48];
         end
         ST_DISPATCH: begin
            res_x_ff   <= cx_ff;
            res_y_ff   <= cy_ff;
            res_s_ff   <= outside ? 16'd0 : 16'(s_sat);
            res_f_ff   <= outside ? 16'd0 : 16'(f_sat);
            res_st_ff  <= outside ? STAT_OUTSIDE : STAT_OK;
            pend_st_ff <= (act_ff == ACT_STEP) ? STAT_ZERO : STAT_OK;
         end
         ST_NB_ADDR: begin
            cand_x_ff <= nx[7:0];
            cand_y_ff <= ny[7:0];
            if (!nb_inside && k_ff == 3'd7) pend_st_ff <= STAT_NONE;
         end
         ST_NB_PICK: begin
            if (take) begin
               best_ff   <= gain;
               best_x_ff <= cand_x_ff;
               best_y_ff <= cand_y_ff;
            end
         end
         ST_CTR_DATA: begin
            res_s_ff  <= 16'(s_rd_ff);
            res_f_ff  <= 16'(f_rd_ff);
            res_st_ff <= pend_st_ff;
         end
         ST_BEST_WR: begin
            res_x_ff  <= best_x_ff;
            res_y_ff  <= best_y_ff;
            res_s_ff  <= 16'(s_rd_ff);
            res_f_ff  <= 16'(f_inc);
            res_st_ff <= STAT_OK;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {res_f_ff, res_s_ff, res_y_ff, res_x_ff};
         rsp_st_ff   <= res_st_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign csr_ready  = 1'b1;

endmodule

@@ design/gndep_gain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gndep_gain
// Two-stage unit for min(ns, max(0, nf*s - ns*f)): products, then gain.
// ----------------------------------------------------------------------------
module gndep_gain #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic [COUNT_BITS-1:0] sample_count,
   input  logic [COUNT_BITS-1:0] field_count,
   input  logic [31:0]           sample_total,
   input  logic [31:0]           field_total,
   output logic [31:0]           gain
);
   import gndep_pkg::*;

   localparam int PW = 32 + COUNT_BITS;

   logic [PW-1:0] prod_a_ff;
   logic [PW-1:0] prod_b_ff;
   logic [31:0]   ns_d_ff;
   logic [31:0]   gain_ff;
   logic [PW-1:0] excess;

   // stage one: the two products
   always_ff @(posedge clock) begin
      prod_a_ff <= PW'(field_total) * PW'(sample_count);
      prod_b_ff <= PW'(sample_total) * PW'(field_count);
      ns_d_ff   <= sample_total;
   end

   // stage two: clipped excess, capped at the sample total
   always_comb begin
      excess = (prod_a_ff > prod_b_ff) ? (prod_a_ff - prod_b_ff) : '0;
   end

   always_ff @(posedge clock) begin
      gain_ff <= (excess < PW'(ns_d_ff)) ? excess[31:0] : ns_d_ff;
   end

   assign gain = gain_ff;

endmodule

@@ design/gndep_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gndep_checker
// Port-level checks for the greedy neighbor deposit step block.
// ----------------------------------------------------------------------------
module gndep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import gndep_pkg::*;

   // one item at a time: ready drops after an accepted transaction
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req accepted while an item is in flight");

   // a new result only appears from a busy block
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without an item in flight");

   // out-of-grid results carry zero counts
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STAT_OUTSIDE) |-> (rsp_tdata[47:16] == '0))
      else $error("out-of-grid result with nonzero counts");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind greedy_neighbor_deposit_step gndep_checker u_gndep_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
